FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions with reset disable, for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check with a fixed message
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// check with a caller message
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

`endif

FILE: design/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// types, codes and helpers shared by the hex record parser files
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned EventW  = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned OutDataW = 56;

  // event codes
  localparam logic [EventW-1:0] EV_CONSUMED = 3'd0;
  localparam logic [EventW-1:0] EV_DATA     = 3'd1;
  localparam logic [EventW-1:0] EV_ACCEPTED = 3'd2;
  localparam logic [EventW-1:0] EV_ERROR    = 3'd3;
  localparam logic [EventW-1:0] EV_HALTED   = 3'd4;

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE   = 3'd0;
  localparam logic [ErrW-1:0] ERR_START  = 3'd1;
  localparam logic [ErrW-1:0] ERR_DIGIT  = 3'd2;
  localparam logic [ErrW-1:0] ERR_TYPE   = 3'd3;
  localparam logic [ErrW-1:0] ERR_CSUM   = 3'd4;
  localparam logic [ErrW-1:0] ERR_LENGTH = 3'd5;

  // record types
  localparam logic [ByteW-1:0] REC_DATA      = 8'h00;
  localparam logic [ByteW-1:0] REC_EOF       = 8'h01;
  localparam logic [ByteW-1:0] REC_EXT_SEG   = 8'h02;
  localparam logic [ByteW-1:0] REC_START_SEG = 8'h03;
  localparam logic [ByteW-1:0] REC_EXT_LIN   = 8'h04;
  localparam logic [ByteW-1:0] REC_START_LIN = 8'h05;

  localparam logic [CharW-1:0] CHAR_COLON = 8'h3A;

  typedef struct packed {
    logic [EventW-1:0] event_kind;
    logic [ByteW-1:0]  data_byte;
    logic [WordW-1:0]  address_upper;
    logic [WordW-1:0]  address_lower;
    logic [ByteW-1:0]  record_kind;
    logic [ErrW-1:0]   error_code;
  } result_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // record end check, first failure wins
  function automatic logic [ErrW-1:0] end_check(input logic [ByteW-1:0] rec_type,
                                                input logic [ByteW-1:0] len,
                                                input logic [ByteW-1:0] sum);
    logic [ErrW-1:0] e;
    e = ERR_NONE;
    if (rec_type > REC_START_LIN) begin
      e = ERR_TYPE;
    end else if (sum != 8'h00) begin
      e = ERR_CSUM;
    end else begin
      case (rec_type)
        REC_EOF:                    if (len != 8'd0) e = ERR_LENGTH;
        REC_EXT_SEG, REC_EXT_LIN:   if (len != 8'd2) e = ERR_LENGTH;
        REC_START_SEG, REC_START_LIN: if (len != 8'd4) e = ERR_LENGTH;
        default:                    e = ERR_NONE;
      endcase
    end
    return e;
  endfunction

endpackage

FILE: design/ihex_parser.sv
// ----------------------------------------------------------------------------
// ihex_parser
// record state machine: one character step per enable, result out combinational
// ----------------------------------------------------------------------------
module ihex_parser
  import ihex_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  output result_t          res_o
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_COUNT, PH_OFFSET, PH_TYPE, PH_DATA, PH_CSUM, PH_HALT
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             second_q, second_d;
  logic [3:0]       nibble_q, nibble_d;
  logic [ByteW-1:0] idx_q, idx_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [WordW-1:0] offset_q, offset_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [WordW-1:0] upper_q, upper_d;
  logic [WordW-1:0] pending_q, pending_d;
  logic [ErrW-1:0]  err_q, err_d;

  logic [4:0]       dig;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] sum_new;
  logic [ErrW-1:0]  chk;
  logic [EventW-1:0] ev;
  logic [ByteW-1:0] out_byte;
  logic [WordW-1:0] out_lower;

  assign dig     = hex_digit(char_i);
  assign b       = {nibble_q, dig[3:0]};
  assign sum_new = sum_q + b;
  assign chk     = end_check(type_q, len_q, sum_new);

  always_comb begin
    phase_d   = phase_q;
    second_d  = second_q;
    nibble_d  = nibble_q;
    idx_d     = idx_q;
    len_d     = len_q;
    offset_d  = offset_q;
    type_d    = type_q;
    sum_d     = sum_q;
    upper_d   = upper_q;
    pending_d = pending_q;
    err_d     = err_q;
    ev        = EV_CONSUMED;
    out_byte  = '0;
    out_lower = '0;

    case (phase_q)
      PH_WAIT: begin
        if (is_blank(char_i)) begin
          ev = EV_CONSUMED;
        end else if (char_i == CHAR_COLON) begin
          phase_d  = PH_COUNT;
          second_d = 1'b0;
          idx_d    = '0;
          offset_d = '0;
          sum_d    = '0;
        end else begin
          err_d   = ERR_START;
          phase_d = PH_HALT;
          ev      = EV_ERROR;
        end
      end
      PH_COUNT, PH_OFFSET, PH_TYPE, PH_DATA, PH_CSUM: begin
        if (!dig[4]) begin
          err_d   = ERR_DIGIT;
          phase_d = PH_HALT;
          ev      = EV_ERROR;
        end else if (!second_q) begin
          nibble_d = dig[3:0];
          second_d = 1'b1;
        end else begin
          second_d = 1'b0;
          sum_d    = sum_new;
          case (phase_q)
            PH_COUNT: begin
              len_d   = b;
              idx_d   = '0;
              phase_d = PH_OFFSET;
            end
            PH_OFFSET: begin
              offset_d = {offset_q[ByteW-1:0], b};
              if (idx_q != 8'd0) begin
                idx_d   = '0;
                phase_d = PH_TYPE;
              end else begin
                idx_d = idx_q + 8'd1;
              end
            end
            PH_TYPE: begin
              type_d  = b;
              idx_d   = '0;
              phase_d = (len_q != 8'd0) ? PH_DATA : PH_CSUM;
            end
            PH_DATA: begin
              if (idx_q == 8'd0) begin
                pending_d[WordW-1:ByteW] = b;
              end else if (idx_q == 8'd1) begin
                pending_d[ByteW-1:0] = b;
              end
              idx_d = idx_q + 8'd1;
              if ((idx_q + 8'd1) >= len_q) phase_d = PH_CSUM;
              if (type_q == REC_DATA) begin
                ev        = EV_DATA;
                out_byte  = b;
                out_lower = offset_q + {8'd0, idx_q};
              end
            end
            default: begin
              if (chk != ERR_NONE) begin
                err_d   = chk;
                phase_d = PH_HALT;
                ev      = EV_ERROR;
              end else begin
                if (type_q == REC_EXT_LIN) upper_d = pending_q;
                phase_d = PH_WAIT;
                ev      = EV_ACCEPTED;
              end
            end
          endcase
        end
      end
      default: begin
        ev = EV_HALTED;
      end
    endcase
  end

  assign res_o = '{event_kind:    ev,
                   data_byte:     out_byte,
                   address_upper: upper_d,
                   address_lower: out_lower,
                   record_kind:   type_d,
                   error_code:    err_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      second_q  <= 1'b0;
      nibble_q  <= '0;
      idx_q     <= '0;
      len_q     <= '0;
      offset_q  <= '0;
      type_q    <= '0;
      sum_q     <= '0;
      upper_q   <= '0;
      pending_q <= '0;
      err_q     <= ERR_NONE;
    end else if (step_i) begin
      phase_q   <= phase_d;
      second_q  <= second_d;
      nibble_q  <= nibble_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      offset_q  <= offset_d;
      type_q    <= type_d;
      sum_q     <= sum_d;
      upper_q   <= upper_d;
      pending_q <= pending_d;
      err_q     <= err_d;
    end
  end

endmodule

FILE: design/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// hex text to load bytes with 32-bit addresses, record checks and status
// ----------------------------------------------------------------------------
// Takes one ASCII character per transfer and returns exactly one result per
// character. A character is registered on entry, then the parser state is
// updated and the result lands in the output register, so a new character
// is taken every cycle while the output side keeps up; the parser's state
// update per step sets that rate. Data bytes leave before their record's
// checksum is seen: drop them if the record later reports an error. After
// the first error every character returns the halted event until reset.
module intel_hex_record_parser
  import ihex_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] text_char
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] data_byte, [23:8] address_upper,
                                              // [39:24] address_lower, [47:40] record_kind,
                                              // [50:48] error_code, [55:51] zero
  output logic [EventW-1:0]   m_axis_tuser    // [2:0] event_kind
);

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          res;
  logic             advance;
  logic             step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  ihex_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_char_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_char_q <= s_axis_tdata;
    if (step) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.event_kind;
  assign m_axis_tdata  = {5'd0, out_q.error_code, out_q.record_kind,
                          out_q.address_lower, out_q.address_upper, out_q.data_byte};

endmodule

FILE: design/ihex_checker.sv
// ----------------------------------------------------------------------------
// ihex_checker
// port-level checks for the hex record parser, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ihex_checker
  import ihex_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [EventW-1:0]   m_axis_tuser
);

  logic [ErrW-1:0]            err;
  logic                       bad_event;
  logic                       stall;
  logic [EventW+OutDataW-1:0] out_word;
  logic                       ev_ok;
  logic                       err_ok;
  logic                       no_data;
  logic                       data_clear;

  assign err        = m_axis_tdata[50:48];
  assign bad_event  = (m_axis_tuser == EV_ERROR) || (m_axis_tuser == EV_HALTED);
  assign stall      = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tuser, m_axis_tdata};
  assign ev_ok      = (m_axis_tuser <= EV_HALTED);
  assign err_ok     = (bad_event == (err != ERR_NONE));
  assign no_data    = m_axis_tvalid && (m_axis_tuser != EV_DATA);
  assign data_clear = (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[39:24] == 16'd0);

  // stalled result holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, stall |=> m_axis_tvalid && $stable(out_word))

  `ASSERT_CLK_MSG(a_event_range, clk_i, rst_ni, m_axis_tvalid |-> ev_ok, "bad event code")

  // error code shows exactly on error and halted events
  `ASSERT_CLK_MSG(a_err_match, clk_i, rst_ni, m_axis_tvalid |-> err_ok, "error code mismatch")

  `ASSERT_CLK_MSG(a_data_zero, clk_i, rst_ni, no_data |-> data_clear, "stray data fields")

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
